@@ rtl/fbba_pkg.sv @@
// ----------------------------------------------------------------------------
// fbba_pkg: shared types and constants of the free block bitmap allocator
// Item layouts, register indexes, method and kind codes, and the command and
// status groups that join controller and datapath.
// ----------------------------------------------------------------------------
package fbba_pkg;

   // Default number of disk blocks tracked by the bitmap
   localparam int MAX_BLOCKS_DEF = 64;

   // Fixed field widths
   localparam int NEED_W  = 14;
   localparam int BIDX_W  = 6;
   localparam int COUNT_W = 7;
   localparam int EPB_W   = 8;
   localparam int CAP_W   = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;

   // Register reset values
   localparam logic [EPB_W-1:0]   EPB_RESET   = 8'd4;
   localparam logic [COUNT_W-1:0] TOTAL_RESET = 7'd64;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_EPB   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL = 1'b1;

   // Item kinds
   localparam logic KIND_SEARCH = 1'b0;
   localparam logic KIND_UPDATE = 1'b1;

   // Allocation methods
   localparam logic [1:0] METH_CONTIG  = 2'd0;
   localparam logic [1:0] METH_LINKED  = 2'd1;
   localparam logic [1:0] METH_INDEXED = 2'd2;
   localparam logic [1:0] METH_CUSTOM  = 2'd3;

   // Input item
   typedef struct packed {
      logic              kind;
      logic [NEED_W-1:0] entries_needed;
      logic [1:0]        method;
      logic [BIDX_W-1:0] target_block;
      logic              mark_free;
   } req_type;

   // Result item
   typedef struct packed {
      logic [BIDX_W-1:0]  block_index;
      logic               found;
      logic               last;
      logic [COUNT_W-1:0] blocks_scanned;
      logic [COUNT_W-1:0] free_count;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic load;          // latch item, restart scan
      logic scan_step;     // examine one block
      logic update;        // write one map bit, answer
      logic recount_init;  // clear free count and walk index
      logic recount_step;  // count one map bit
      logic emit_single;   // one closing item, no block chosen
      logic single_found;  // found flag of that item
      logic emit_step;     // one chosen index
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic n_zero;        // no blocks in use
      logic cap_init_ge;   // starting capacity already fits
      logic hit;           // capacity fits after this block
      logic blk_last;      // walk sits on the last block in use
      logic cnt_nx_zero;   // no candidate after this block
      logic emit_last;     // emitting the final candidate
   } status_type;

endpackage

@@ rtl/fbba_ctrl.sv @@
// ----------------------------------------------------------------------------
// fbba_ctrl: allocator sequencer
// Walks an update item through its update phase and a search item through
// scan and emit phases, and runs the free count recount after a block count write.
// ----------------------------------------------------------------------------
module fbba_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 req_kind,
   input  logic                 csr_total_wr,
   input  fbba_pkg::status_type status,
   output fbba_pkg::cmd_type    cmd,
   output logic                 busy
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPD,
      ST_SCAN,
      ST_EMIT,
      ST_RECNT
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;

   // Decide next state and issue datapath commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = (req_kind == fbba_pkg::KIND_UPDATE) ? ST_UPD : ST_SCAN;
            end else if (csr_total_wr) begin
               cmd.recount_init = 1'b1;
               state_in         = ST_RECNT;
            end
         end
         ST_UPD: begin
            cmd.update = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_SCAN: begin
            if (status.n_zero) begin
               cmd.emit_single  = 1'b1;
               cmd.single_found = status.cap_init_ge;
               state_in         = ST_IDLE;
            end else begin
               cmd.scan_step = 1'b1;
               if (status.hit) begin
                  if (status.cnt_nx_zero) begin
                     cmd.emit_single  = 1'b1;
                     cmd.single_found = 1'b1;
                     state_in         = ST_IDLE;
                  end else begin
                     state_in = ST_EMIT;
                  end
               end else if (status.blk_last) begin
                  cmd.emit_single  = 1'b1;
                  cmd.single_found = 1'b0;
                  state_in         = ST_IDLE;
               end
            end
         end
         ST_EMIT: begin
            cmd.emit_step = 1'b1;
            if (status.emit_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_RECNT: begin
            cmd.recount_step = 1'b1;
            if (status.n_zero || status.blk_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and busy flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != ST_IDLE);
      end
   end

   assign busy = busy_ff;

endmodule

@@ rtl/fbba_dpath.sv @@
// ----------------------------------------------------------------------------
// fbba_dpath: allocator datapath
// Free bitmap, free counter, configuration registers, capacity accumulator,
// candidate list memory and the result register.
// ----------------------------------------------------------------------------
module fbba_dpath #(
   parameter int MAX_BLOCKS = fbba_pkg::MAX_BLOCKS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  fbba_pkg::req_type                   req_data,
   input  logic                                csr_wr,
   input  logic [fbba_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fbba_pkg::CSR_DATA_W-1:0]     csr_data,
   input  fbba_pkg::cmd_type                   cmd,
   output fbba_pkg::status_type                status,
   output logic                                rsp_strobe,
   output fbba_pkg::rsp_type                   rsp_data
);

   localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
   localparam int CAP_W = fbba_pkg::CAP_W;
   localparam logic [fbba_pkg::COUNT_W-1:0] MAX_CNT = fbba_pkg::COUNT_W'(MAX_BLOCKS);

   // Configuration and bitmap state
   logic [fbba_pkg::EPB_W-1:0]   epb_ff;
   logic [fbba_pkg::COUNT_W-1:0] total_ff;
   logic [MAX_BLOCKS-1:0]        map_ff;
   logic [CNT_W-1:0]             free_cnt_ff;

   // Latched item
   fbba_pkg::req_type req_ff;

   // Scan state
   logic [IDX_W-1:0]        walk_ff;
   logic signed [CAP_W-1:0] cap_ff;
   logic [CNT_W-1:0]        cand_cnt_ff;
   logic [CNT_W-1:0]        emit_k_ff;
   logic [CNT_W-1:0]        scanned_ff;
   logic [IDX_W-1:0]        cand_mem [MAX_BLOCKS];

   // Result register
   logic                    rsp_valid_ff;
   logic [IDX_W-1:0]        rsp_idx_ff;
   logic                    rsp_found_ff;
   logic                    rsp_last_ff;

   logic [fbba_pkg::COUNT_W-1:0] n_eff7;
   logic [CNT_W-1:0]             n_eff;
   logic [CNT_W-1:0]             n_last;
   logic                         walk_at_last;
   logic                         free_bit;
   logic                         reset_meth;
   logic signed [CAP_W-1:0]      cap_add;
   logic signed [CAP_W-1:0]      cap_init;
   logic signed [CAP_W-1:0]      cap_nx;
   logic signed [CAP_W-1:0]      need_s;
   logic                         upd_ok;
   logic [IDX_W-1:0]             upd_idx;
   logic                         upd_old;

   // Effective block count
   assign n_eff7       = (total_ff > MAX_CNT) ? MAX_CNT : total_ff;
   assign n_eff        = n_eff7[CNT_W-1:0];
   assign n_last       = n_eff - CNT_W'(1);
   assign walk_at_last = (CNT_W'(walk_ff) == n_last);

   // Capacity step for the block under the walk
   assign free_bit   = map_ff[walk_ff];
   assign reset_meth = (req_ff.method == fbba_pkg::METH_CONTIG) ||
                       (req_ff.method == fbba_pkg::METH_CUSTOM);
   assign cap_add    = (req_ff.method == fbba_pkg::METH_LINKED) ?
                       CAP_W'(epb_ff) - CAP_W'(1) : CAP_W'(epb_ff);
   assign cap_init   = (req_data.method == fbba_pkg::METH_INDEXED) ?
                       -CAP_W'(epb_ff) : '0;
   assign need_s     = CAP_W'(req_ff.entries_needed);

   always_comb begin
      if (free_bit) begin
         cap_nx = cap_ff + cap_add;
      end else if (reset_meth) begin
         cap_nx = '0;
      end else begin
         cap_nx = cap_ff;
      end
   end

   // Update target check
   assign upd_ok  = ({1'b0, req_ff.target_block} < n_eff7);
   assign upd_idx = req_ff.target_block[IDX_W-1:0];
   assign upd_old = map_ff[upd_idx];

   // Report status
   always_comb begin
      status             = '0;
      status.n_zero      = (n_eff == '0);
      status.cap_init_ge = (cap_ff >= need_s);
      status.hit         = (cap_nx >= need_s);
      status.blk_last    = walk_at_last;
      status.cnt_nx_zero = free_bit ? 1'b0 : (reset_meth ? 1'b1 : (cand_cnt_ff == '0));
      status.emit_last   = (emit_k_ff == cand_cnt_ff - CNT_W'(1));
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         epb_ff   <= fbba_pkg::EPB_RESET;
         total_ff <= fbba_pkg::TOTAL_RESET;
      end else if (csr_wr) begin
         unique case (csr_index)
            fbba_pkg::CSR_EPB:   epb_ff   <= csr_data;
            fbba_pkg::CSR_TOTAL: total_ff <= csr_data[fbba_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Bitmap and free counter
   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff      <= '1;
         free_cnt_ff <= CNT_W'(MAX_BLOCKS);
      end else if (cmd.update) begin
         if (upd_ok) begin
            map_ff[upd_idx] <= req_ff.mark_free;
            if (upd_old != req_ff.mark_free) begin
               free_cnt_ff <= req_ff.mark_free ? free_cnt_ff + CNT_W'(1)
                                               : free_cnt_ff - CNT_W'(1);
            end
         end
      end else if (cmd.recount_init) begin
         free_cnt_ff <= '0;
      end else if (cmd.recount_step && !status.n_zero) begin
         free_cnt_ff <= free_cnt_ff + CNT_W'(free_bit);
      end
   end

   // Latch item and advance the scan
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff      <= req_data;
         walk_ff     <= '0;
         cap_ff      <= cap_init;
         cand_cnt_ff <= '0;
         emit_k_ff   <= '0;
         scanned_ff  <= '0;
      end else if (cmd.recount_init) begin
         walk_ff <= '0;
      end else if (cmd.recount_step) begin
         walk_ff <= walk_ff + IDX_W'(1);
      end else if (cmd.scan_step) begin
         walk_ff    <= walk_ff + IDX_W'(1);
         cap_ff     <= cap_nx;
         scanned_ff <= CNT_W'(walk_ff) + CNT_W'(1);
         if (free_bit) begin
            cand_cnt_ff <= cand_cnt_ff + CNT_W'(1);
         end else if (reset_meth) begin
            cand_cnt_ff <= '0;
         end
      end else if (cmd.emit_step) begin
         emit_k_ff <= emit_k_ff + CNT_W'(1);
      end
   end

   // Candidate list write
   always_ff @(posedge clock) begin
      if (cmd.scan_step && free_bit) begin
         cand_mem[cand_cnt_ff[IDX_W-1:0]] <= walk_ff;
      end
   end

   // Result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.update || cmd.emit_single || cmd.emit_step;
      end
   end

   // Result payload, candidate read registered here
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         rsp_idx_ff   <= upd_idx;
         rsp_found_ff <= upd_ok;
         rsp_last_ff  <= 1'b1;
      end else if (cmd.emit_single) begin
         rsp_idx_ff   <= '0;
         rsp_found_ff <= cmd.single_found;
         rsp_last_ff  <= 1'b1;
      end else if (cmd.emit_step) begin
         rsp_idx_ff   <= cand_mem[emit_k_ff[IDX_W-1:0]];
         rsp_found_ff <= 1'b1;
         rsp_last_ff  <= status.emit_last;
      end
   end

   // Drive result ports; target index echoes in full on an update
   always_comb begin
      rsp_data                = '0;
      rsp_data.block_index    = fbba_pkg::BIDX_W'(rsp_idx_ff);
      rsp_data.found          = rsp_found_ff;
      rsp_data.last           = rsp_last_ff;
      rsp_data.blocks_scanned = fbba_pkg::COUNT_W'(scanned_ff);
      rsp_data.free_count     = fbba_pkg::COUNT_W'(free_cnt_ff);
      if (req_ff.kind == fbba_pkg::KIND_UPDATE) begin
         rsp_data.block_index = req_ff.target_block;
      end
   end

   assign rsp_strobe = rsp_valid_ff;

endmodule

@@ rtl/free_block_bitmap_allocator_core.sv @@
// ----------------------------------------------------------------------------
// free_block_bitmap_allocator_core: free block bitmap allocator
// Keeps a free/used bit per disk block and a free count; answers updates
// with an acknowledgement and searches with a list of chosen free blocks.
// ----------------------------------------------------------------------------
// Results leave on rsp_strobe for one cycle each and cannot be stalled, so
// the receiver must take every result as it comes. An update passes through
// the update state to its single result. A search walks the bitmap one
// block per cycle (a single result and no walk if no block is in use) and
// then sends its chosen indices one per cycle from the candidate memory.
// Block indices come out in ascending order with last set on the final one.
// A write to total_blocks starts a recount of the free count, one block per
// cycle over the blocks in use; busy stays high and csr_ready low meanwhile.
// Configuration is taken only while busy is low and start is low.
module free_block_bitmap_allocator_core #(
   parameter int MAX_BLOCKS = fbba_pkg::MAX_BLOCKS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  fbba_pkg::req_type               req_data,
   output logic                            rsp_strobe,
   output fbba_pkg::rsp_type               rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [fbba_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fbba_pkg::CSR_DATA_W-1:0] csr_data
);

   fbba_pkg::cmd_type    cmd;
   fbba_pkg::status_type status;
   logic                 csr_wr;
   logic                 csr_total_wr;

   // Take configuration only while idle and no item arrives
   assign csr_ready    = !busy && !start;
   assign csr_wr       = csr_valid && csr_ready;
   assign csr_total_wr = csr_wr && (csr_index == fbba_pkg::CSR_TOTAL);

   fbba_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .req_kind     (req_data.kind),
      .csr_total_wr (csr_total_wr),
      .status       (status),
      .cmd          (cmd),
      .busy         (busy)
   );

   fbba_dpath #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .csr_wr     (csr_wr),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule
